/* rtl/isc_pkg.sv */
// shared constants and types for the induced subgraph acyclicity check
`default_nettype none
package isc_pkg;

	// graph size and field widths
	localparam int MAX_VERTICES = 32;
	localparam int ROW_W        = 32;
	localparam int RIDX_W       = 5;
	localparam int NV_W         = 6;
	localparam int NV_RESET     = 32;
	// vertices that can take part in a round: rows and masks are ROW_W bits
	localparam int USE_V        = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;
	// round counter, holds 0..MAX_VERTICES
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

	// command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef logic [MAX_VERTICES-1:0][ROW_W-1:0] row_arr_t;

	// operands handed from the sequencer to the round unit
	typedef struct packed {
		logic [ROW_W-1:0] live;
		logic [ROW_W-1:0] subset;
		logic [CNT_W-1:0] n;
	} round_req_t;

endpackage
`default_nettype wire

/* rtl/isc_row_store.sv */
// successor row storage, one row written per transaction, all rows visible
`default_nettype none
module isc_row_store (
	input  wire                        clk,
	input  wire                        wr_en,
	input  wire [isc_pkg::RIDX_W-1:0]  wr_index,
	input  wire [isc_pkg::ROW_W-1:0]   wr_data,
	output isc_pkg::row_arr_t          rows
);
	import isc_pkg::*;

	row_arr_t rows_q;

	// decoded write, indexes beyond the store are dropped
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			if (wr_en && (int'(wr_index) == i)) begin
				rows_q[i] <= wr_data;
			end
		end
	end

	assign rows = rows_q;

endmodule
`default_nettype wire

/* rtl/isc_round_unit.sv */
// one propagation round: masked union of the successor rows of live vertices
`default_nettype none
module isc_round_unit (
	input  wire isc_pkg::round_req_t   req,
	input  wire isc_pkg::row_arr_t     rows,
	output logic [isc_pkg::ROW_W-1:0]  next_live
);
	import isc_pkg::*;

	// or of selected rows, each gated by live bit and vertex count
	always_comb begin
		logic [ROW_W-1:0] acc;
		acc = '0;
		for (int v = 0; v < USE_V; v++) begin
			if (req.live[v] && (v < int'(req.n))) begin
				acc = acc | rows[v];
			end
		end
		next_live = acc & req.subset;
	end

endmodule
`default_nettype wire

/* rtl/isc_seq.sv */
// round sequencer, vertex count register and result register
`default_nettype none
module isc_seq (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	input  wire                        cmd,
	input  wire [isc_pkg::ROW_W-1:0]   vertex_subset,
	input  wire                        cfg_we,
	input  wire [isc_pkg::NV_W-1:0]    cfg_wdata,
	input  wire [isc_pkg::ROW_W-1:0]   next_live,
	output isc_pkg::round_req_t        req,
	output logic                       busy,
	output logic                       result_valid,
	output logic                       is_acyclic
);
	import isc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t            state_q;
	logic [NV_W-1:0]   num_vertices_q;
	logic [ROW_W-1:0]  live_q;
	logic [ROW_W-1:0]  subset_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  round_q;
	logic              result_valid_q;
	logic              is_acyclic_q;
	logic [CNT_W-1:0]  n_sat;
	logic              query_go;
	logic              round_go;

	// vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vertices_q <= NV_W'(NV_RESET);
		end else if (cfg_we) begin
			num_vertices_q <= cfg_wdata;
		end
	end

	// vertex count clipped to the store depth
	always_comb begin
		if (int'(num_vertices_q) > MAX_VERTICES) begin
			n_sat = CNT_W'(MAX_VERTICES);
		end else begin
			n_sat = CNT_W'(num_vertices_q);
		end
	end

	assign busy     = (state_q == ST_RUN);
	assign query_go = start && !busy && (cmd == CMD_QUERY);
	assign round_go = (round_q < n_q) && (live_q != '0);

	// control state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			round_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (query_go) begin
						state_q <= ST_RUN;
						round_q <= '0;
					end
				end
				ST_RUN: begin
					if (round_go) begin
						round_q <= round_q + CNT_W'(1);
					end else begin
						state_q        <= ST_IDLE;
						result_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// live set, subset and result payload
	always_ff @(posedge clk) begin
		if (query_go) begin
			live_q   <= vertex_subset;
			subset_q <= vertex_subset;
			n_q      <= n_sat;
		end else if (busy && round_go) begin
			live_q <= next_live;
		end
		if (busy && !round_go) begin
			is_acyclic_q <= (live_q == '0);
		end
	end

	assign req          = '{live: live_q, subset: subset_q, n: n_q};
	assign result_valid = result_valid_q;
	assign is_acyclic   = is_acyclic_q;

	// a result only follows the last cycle of a run
	a_result_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == ST_RUN))
		else $error("result strobe without a finished run");

	// the round count never passes the clipped vertex count
	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (round_q <= n_q))
		else $error("round count beyond vertex count");

	// an accepted query always starts a run
	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		query_go |=> busy)
		else $error("query accepted but no run started");

	// the strobe comes with the block ready again
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result strobe while busy");

endmodule
`default_nettype wire

/* rtl/induced_subgraph_acyclicity_check_top.sv */
// top level of the induced subgraph acyclicity check
// a query runs r rounds after acceptance, r being at most the clipped vertex count, and
// then strobes result_valid; a new query is taken only once the previous one is done
// the single round unit does one masked union of all successor rows per cycle while
// a query runs; a row write is taken only while the block is not busy
// reset: sequencer cleared, vertex count 32, rows undefined; receiver cannot stall
`default_nettype none
module induced_subgraph_acyclicity_check_top (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	output logic                       busy,
	input  wire                        cmd,
	input  wire [isc_pkg::RIDX_W-1:0]  row_index,
	input  wire [isc_pkg::ROW_W-1:0]   row_bits,
	input  wire [isc_pkg::ROW_W-1:0]   vertex_subset,
	input  wire                        cfg_we,
	input  wire [isc_pkg::NV_W-1:0]    cfg_wdata,
	output logic                       result_valid,
	output logic                       is_acyclic
);
	import isc_pkg::*;

	row_arr_t          rows;
	round_req_t        req;
	logic [ROW_W-1:0]  next_live;
	logic              wr_en;

	// row write transaction
	assign wr_en = start && !busy && (cmd == CMD_WRITE);

	isc_row_store u_store (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_index (row_index),
		.wr_data  (row_bits),
		.rows     (rows)
	);

	isc_round_unit u_round (
		.req       (req),
		.rows      (rows),
		.next_live (next_live)
	);

	isc_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.cmd           (cmd),
		.vertex_subset (vertex_subset),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.next_live     (next_live),
		.req           (req),
		.busy          (busy),
		.result_valid  (result_valid),
		.is_acyclic    (is_acyclic)
	);

endmodule
`default_nettype wire
